@@ rtl/assert_macros.svh @@
// Assertion macros shared by the responder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/ps2dcr_pkg.sv @@
// Shared types and byte codes for the PS/2 device command responder.
// No dependencies; imported by every module of the block.
package ps2dcr_pkg;

    localparam int S_TDATA_W = 48;

    // input opcode
    localparam logic OP_HOST  = 1'b0;
    localparam logic OP_MOUSE = 1'b1;

    // device kind register
    localparam logic KIND_KEYBOARD = 1'b0;
    localparam logic KIND_MOUSE    = 1'b1;

    // host command codes
    localparam logic [7:0] CMD_LEDS     = 8'hED;
    localparam logic [7:0] CMD_ECHO     = 8'hEE;
    localparam logic [7:0] CMD_SCANSET  = 8'hF0;
    localparam logic [7:0] CMD_GET_ID   = 8'hF2;
    localparam logic [7:0] CMD_SCALING  = 8'hE6;
    localparam logic [7:0] CMD_RES      = 8'hE8;
    localparam logic [7:0] CMD_RATE     = 8'hF3;
    localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
    localparam logic [7:0] CMD_RESEND   = 8'hFE;
    localparam logic [7:0] CMD_RESET    = 8'hFF;

    // reply bytes
    localparam logic [7:0] RSP_ACK     = 8'hFA;
    localparam logic [7:0] RSP_NAK     = 8'hFE;
    localparam logic [7:0] RSP_ECHO    = 8'hEE;
    localparam logic [7:0] RSP_BAT_OK  = 8'hAA;
    localparam logic [7:0] RSP_KB_ID0  = 8'hAB;
    localparam logic [7:0] RSP_KB_ID1  = 8'h83;
    localparam logic [7:0] RSP_ZERO    = 8'h00;
    localparam logic [7:0] RSP_SET2    = 8'h02;

    typedef enum logic [2:0] {
        PEND_NONE       = 3'd0,
        PEND_LEDS       = 3'd1,
        PEND_SCANSET    = 3'd2,
        PEND_SCALING    = 3'd3,
        PEND_RESOLUTION = 3'd4,
        PEND_RATE       = 3'd5
    } t_pend;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         host_byte;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [2:0]         buttons;
    } t_item;

    // bytes[0] goes out first; count is 1..3
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } t_reply;

endpackage

@@ rtl/ps2dcr_decode.sv @@
// Command decoder and argument state of the PS/2 responder.
// Depends on ps2dcr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ps2dcr_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_kind,
    input  ps2dcr_pkg::t_item  i_item,
    output ps2dcr_pkg::t_reply o_reply
);
    import ps2dcr_pkg::*;

    logic        r_await, n_await;
    t_pend       r_pend, n_pend;
    logic [15:0] ax, ay;
    logic [7:0]  flag;
    logic        handled;

    always_comb begin
        ax = i_item.move_x[15] ? (~i_item.move_x + 16'd1) : i_item.move_x;
        ay = i_item.move_y[15] ? (~i_item.move_y + 16'd1) : i_item.move_y;
        flag = {(ax[15:8] != 8'd0), (ay[15:8] != 8'd0), i_item.move_x[15],
                i_item.move_y[15], 1'b1, i_item.buttons[0], i_item.buttons[1],
                i_item.buttons[2]};
    end

    always_comb begin
        n_await = r_await;
        n_pend  = r_pend;
        handled = 1'b1;
        o_reply.bytes = '0;
        o_reply.count = 2'd1;
        o_reply.bytes[0] = RSP_NAK;
        if (i_item.opcode == OP_MOUSE) begin
            o_reply.bytes[0] = flag;
            o_reply.bytes[1] = (ax[15:8] != 8'd0) ? 8'd1 : ax[7:0];
            o_reply.bytes[2] = (ay[15:8] != 8'd0) ? 8'd1 : ay[7:0];
            o_reply.count = 2'd3;
        end else if (r_await) begin
            o_reply.bytes[0] = RSP_ACK;
            if (r_pend == PEND_SCANSET && i_item.host_byte == 8'd0) begin
                o_reply.bytes[1] = RSP_SET2;
                o_reply.count = 2'd2;
            end
            n_await = 1'b0;
            n_pend  = PEND_NONE;
        end else begin
            if (i_kind == KIND_KEYBOARD) begin
                case (i_item.host_byte)
                    CMD_LEDS: begin
                        o_reply.bytes[0] = RSP_ACK;
                        n_await = 1'b1;
                        n_pend  = PEND_LEDS;
                    end
                    CMD_ECHO: o_reply.bytes[0] = RSP_ECHO;
                    CMD_SCANSET: begin
                        o_reply.bytes[0] = RSP_ACK;
                        n_await = 1'b1;
                        n_pend  = PEND_SCANSET;
                    end
                    CMD_GET_ID: begin
                        o_reply.bytes[0] = RSP_ACK;
                        o_reply.bytes[1] = RSP_KB_ID0;
                        o_reply.bytes[2] = RSP_KB_ID1;
                        o_reply.count = 2'd3;
                    end
                    default: handled = 1'b0;
                endcase
            end else begin
                case (i_item.host_byte)
                    CMD_SCALING: begin
                        o_reply.bytes[0] = RSP_ACK;
                        n_await = 1'b1;
                        n_pend  = PEND_SCALING;
                    end
                    CMD_RES: begin
                        o_reply.bytes[0] = RSP_ACK;
                        n_await = 1'b1;
                        n_pend  = PEND_RESOLUTION;
                    end
                    CMD_GET_ID: begin
                        o_reply.bytes[0] = RSP_ACK;
                        o_reply.bytes[1] = RSP_ZERO;
                        o_reply.count = 2'd2;
                    end
                    default: handled = 1'b0;
                endcase
            end
            if (!handled) begin
                case (i_item.host_byte)
                    CMD_RATE: begin
                        o_reply.bytes[0] = RSP_ACK;
                        n_await = 1'b1;
                        n_pend  = PEND_RATE;
                    end
                    CMD_DEFAULTS: o_reply.bytes[0] = RSP_ACK;
                    CMD_RESEND:   o_reply.bytes[0] = RSP_NAK;
                    CMD_RESET: begin
                        o_reply.bytes[0] = RSP_BAT_OK;
                        o_reply.bytes[1] = RSP_ZERO;
                        o_reply.count = 2'd2;
                    end
                    default: o_reply.bytes[0] = RSP_NAK;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_pend  <= PEND_NONE;
        end else if (i_en) begin
            r_await <= n_await;
            r_pend  <= n_pend;
        end
    end

    `ASSERT_CLK(a_pend_matches_await, (r_await == (r_pend != PEND_NONE)),
                "pending code out of step with argument flag")
    `ASSERT_CLK(a_arg_closes, (i_en && r_await && i_item.opcode == OP_HOST) |=> !r_await,
                "argument byte did not close the pending command")
    `ASSERT_CLK(a_report_keeps_state,
                (i_en && i_item.opcode == OP_MOUSE) |=> $stable(r_await) && $stable(r_pend),
                "mouse report changed command state")
endmodule

@@ rtl/ps2dcr_tx.sv @@
// Reply run register and byte serializer of the PS/2 responder.
// Depends on ps2dcr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ps2dcr_tx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ps2dcr_pkg::t_reply i_reply,
    output logic               o_free,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [7:0]         o_tdata,
    output logic               o_tlast
);
    import ps2dcr_pkg::*;

    logic            r_valid;
    logic [1:0]      r_idx;
    logic [1:0]      r_cnt;
    logic [2:0][7:0] r_bytes;
    logic            beat;

    assign o_tvalid = r_valid;
    assign o_tdata  = r_bytes[r_idx];
    assign o_tlast  = (r_idx == r_cnt - 2'd1);
    assign beat     = r_valid && i_tready;
    // run register can take a new reply once its last beat leaves
    assign o_free   = !r_valid || (beat && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (beat) begin
            if (o_tlast) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_reply.bytes;
            r_cnt   <= i_reply.count;
        end
    end

    `ASSERT_CLK(a_load_only_free, i_load |-> o_free, "reply loaded over a busy run")
    `ASSERT_CLK(a_count_nonzero, r_valid |-> (r_cnt != 2'd0) && (r_idx < r_cnt),
                "run index beyond its byte count")
    `ASSERT_CLK(a_advance, (beat && !o_tlast && !i_load) |=> r_valid && r_idx == $past(r_idx) + 2'd1,
                "serializer did not advance after a beat")
endmodule

@@ rtl/ps2_device_command_responder.sv @@
// Top level of the PS/2 device command responder (keyboard or mouse).
// Depends on ps2dcr_pkg, ps2dcr_decode and ps2dcr_tx.
//
// Use:
//   Slave stream: one beat is a host byte (tuser = 0) or a mouse report to
//   send (tuser = 1). Master stream: reply bytes, tlast on the final byte
//   that one input beat produces. Every input beat yields 1 to 3 bytes.
//   i_cfg_we / i_cfg_wdata set device_kind (0 keyboard, 1 mouse); write it
//   only while the block is idle.
// Timing:
//   A beat lands in the input register, then is decoded combinationally and
//   loaded into the reply run register once that is free; the first reply
//   byte is then on o_m_tdata. The run register sends one byte per cycle
//   while i_m_tready is high, so an item occupies the output for 1 to 3 beats;
//   the next item is decoded in the cycle its last byte leaves, and input
//   is taken while a run is still draining.
// Reset: synchronous, active low; clears the argument wait, the pending
//   command, device_kind (keyboard) and both valid flags.
// Stall: when i_m_tready is low the current byte holds; the input register
//   then fills and o_s_tready drops until the run drains.
module ps2_device_command_responder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // host_byte[7:0], move_x[23:8], move_y[39:24], buttons[42:40], zero pad
    input  logic [ps2dcr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // opcode[0]
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // reply_byte[7:0]
    output logic [7:0]                        o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata
);
    import ps2dcr_pkg::*;

    logic   r_kind;
    logic   r_in_valid;
    t_item  r_item, n_item;
    t_reply reply;
    logic   tx_free;
    logic   load;

    always_comb begin
        n_item.opcode    = i_s_tuser;
        n_item.host_byte = i_s_tdata[7:0];
        n_item.move_x    = i_s_tdata[23:8];
        n_item.move_y    = i_s_tdata[39:24];
        n_item.buttons   = i_s_tdata[42:40];
    end

    // decode fires when an item is held and the run register frees up
    assign load       = r_in_valid && tx_free;
    assign o_s_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_KEYBOARD;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
    end

    ps2dcr_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (load),
        .i_kind  (r_kind),
        .i_item  (r_item),
        .o_reply (reply)
    );

    ps2dcr_tx u_tx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_reply  (reply),
        .o_free   (tx_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for ps2_device_command_responder: host commands and mouse reports
// go in on the slave stream, and the reply bytes are checked against a predictor.
// Depends on ps2dcr_pkg and the responder RTL; it reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2dcr_pkg::*;

    localparam int QUIET_LIMIT  = 1000;   // cycles with no beat on either side
    localparam int RANDOM_ITEMS = 345;
    localparam int DRAIN_CYCLES = 10;

    // one expected reply beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_beat;

    // Predictor of the reply bytes. It keeps its own copy of the device kind and of the
    // open argument command, and queues the bytes that each accepted item should produce.
    class ps2_reply_predictor;
        logic        kind;
        logic        awaiting;
        t_pend       open_cmd;
        t_reply_beat replies_due[$];
        int          errors;

        function new();
            kind     = KIND_KEYBOARD;
            awaiting = 1'b0;
            open_cmd = PEND_NONE;
            errors   = 0;
        endfunction

        function void set_kind(logic k);
            kind = k;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("%t: %s", $realtime, msg);
        endfunction

        function void open_argument(t_pend code, ref logic [7:0] run[$]);
            awaiting = 1'b1;
            open_cmd = code;
            run.push_back(RSP_ACK);
        endfunction

        // work out the reply run of one accepted item
        function void take_item(t_item it);
            logic [7:0]  run[$];
            logic [16:0] ax;
            logic [16:0] ay;
            logic        handled;
            t_reply_beat b;
            if (it.opcode == OP_MOUSE) begin
                // a report is sent in any state and leaves the state alone
                ax = it.move_x[15] ? 17'h10000 - {1'b0, it.move_x} : {1'b0, it.move_x};
                ay = it.move_y[15] ? 17'h10000 - {1'b0, it.move_y} : {1'b0, it.move_y};
                run.push_back({ax > 17'd255, ay > 17'd255, it.move_x[15], it.move_y[15],
                               1'b1, it.buttons[0], it.buttons[1], it.buttons[2]});
                run.push_back(ax > 17'd255 ? 8'd1 : ax[7:0]);
                run.push_back(ay > 17'd255 ? 8'd1 : ay[7:0]);
            end else if (awaiting) begin
                // any byte is an argument here, command codes too
                run.push_back(RSP_ACK);
                if (open_cmd == PEND_SCANSET && it.host_byte == 8'h00)
                    run.push_back(RSP_SET2);
                awaiting = 1'b0;
                open_cmd = PEND_NONE;
            end else begin
                handled = 1'b1;
                if (kind == KIND_KEYBOARD) begin
                    case (it.host_byte)
                        CMD_LEDS:    open_argument(PEND_LEDS, run);
                        CMD_ECHO:    run.push_back(RSP_ECHO);
                        CMD_SCANSET: open_argument(PEND_SCANSET, run);
                        CMD_GET_ID: begin
                            run.push_back(RSP_ACK);
                            run.push_back(RSP_KB_ID0);
                            run.push_back(RSP_KB_ID1);
                        end
                        default:     handled = 1'b0;
                    endcase
                end else begin
                    case (it.host_byte)
                        CMD_SCALING: open_argument(PEND_SCALING, run);
                        CMD_RES:     open_argument(PEND_RESOLUTION, run);
                        CMD_GET_ID: begin
                            run.push_back(RSP_ACK);
                            run.push_back(RSP_ZERO);
                        end
                        default:     handled = 1'b0;
                    endcase
                end
                if (!handled) begin
                    case (it.host_byte)
                        CMD_RATE:     open_argument(PEND_RATE, run);
                        CMD_DEFAULTS: run.push_back(RSP_ACK);
                        CMD_RESEND:   run.push_back(RSP_NAK);
                        CMD_RESET: begin
                            run.push_back(RSP_BAT_OK);
                            run.push_back(RSP_ZERO);
                        end
                        default:      run.push_back(RSP_NAK);
                    endcase
                end
            end
            foreach (run[i]) begin
                b.data = run[i];
                b.last = (i == run.size() - 1);
                replies_due.push_back(b);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_reply_beat want;
            if (replies_due.size() == 0) begin
                note_error($sformatf("unexpected reply beat data=%h last=%b", data, last));
                return;
            end
            want = replies_due.pop_front();
            if (data !== want.data)
                note_error($sformatf("reply data: expected %h, got %h", want.data, data));
            if (last !== want.last)
                note_error($sformatf("reply last: expected %b, got %b (data %h)",
                                     want.last, last, data));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    t_item       s_item = '0;
    logic        m_tready = 1'b1;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 o_m_tvalid;
    logic [7:0]           o_m_tdata;
    logic                 o_m_tlast;

    ps2_reply_predictor model;
    int burst_left = 0;
    int stretch_left = 0;
    int stretch_mode = 0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    // host_byte, move_x, move_y, buttons from bit 0 up, zero padded to 48 bits
    assign s_tdata = {5'b0, s_item.buttons, s_item.move_y, s_item.move_x, s_item.host_byte};

    ps2_device_command_responder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_item.opcode),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Receiver: stretches of always-ready, light stalls, heavy stalls and toggling.
    always @(posedge clk) begin
        if (stretch_left == 0) begin
            stretch_mode = $urandom_range(0, 3);
            stretch_left = $urandom_range(10, 80);
        end else begin
            stretch_left = stretch_left - 1;
        end
        case (stretch_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Monitor: both handshakes seen at the same edge, from pre-edge values.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_m_tvalid && m_tready)
                model.check_byte(o_m_tdata, o_m_tlast);
            if (s_tvalid && o_s_tready)
                model.take_item(s_item);
        end
    end

    // Watchdog: a long stretch with no beat on either side means the block hung.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ps2_device_command_responder test failed");
            $finish;
        end
    end

    // Host byte; the unused report fields carry random filler.
    function automatic t_item host_item(logic [7:0] hb);
        t_item it;
        it.opcode    = OP_HOST;
        it.host_byte = hb;
        it.move_x    = 16'($urandom());
        it.move_y    = 16'($urandom());
        it.buttons   = 3'($urandom());
        return it;
    endfunction

    function automatic t_item report_item(logic signed [15:0] x, logic signed [15:0] y,
                                          logic [2:0] btn);
        t_item it;
        it.opcode    = OP_MOUSE;
        it.host_byte = 8'($urandom());
        it.move_x    = x;
        it.move_y    = y;
        it.buttons   = btn;
        return it;
    endfunction

    // movement that lands near the clipping edge often
    function automatic logic signed [15:0] random_move();
        logic signed [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = $signed(16'($urandom_range(0, 20))) - 16'sd10;
            1:       v = $urandom_range(0, 1) ? 16'sd255 + $signed(16'($urandom_range(0, 2)))
                                              : -16'sd255 - $signed(16'($urandom_range(0, 2)));
            2:       v = 16'($urandom());
            3:       v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: v = $signed(16'($urandom_range(0, 600))) - 16'sd300;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_command(logic kind);
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0:       c = (kind == KIND_KEYBOARD) ? CMD_LEDS : CMD_SCALING;
            1:       c = (kind == KIND_KEYBOARD) ? CMD_SCANSET : CMD_RES;
            2:       c = (kind == KIND_KEYBOARD) ? CMD_ECHO : CMD_GET_ID;
            3:       c = (kind == KIND_KEYBOARD) ? CMD_GET_ID : CMD_RATE;
            4:       c = $urandom_range(0, 1) ? CMD_RATE : CMD_DEFAULTS;
            5:       c = CMD_RESEND;
            default: c = CMD_RESET;
        endcase
        return c;
    endfunction

    // One beat on the slave side. Valid stays up through a burst; a gap may follow a burst.
    task automatic send_beat(input t_item it);
        int gap;
        s_item   <= it;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!o_s_tready)
            @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_host(input logic [7:0] hb);
        send_beat(host_item(hb));
    endtask

    // Hold off the sender until every reply is out, let the block settle, then write
    // device_kind. An open argument wait is state, not activity, so it may stay open.
    // The first negedge lets the monitor note a beat taken at the last edge.
    task automatic set_device_kind(input logic kind);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (model.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= kind;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model.set_kind(kind);
    endtask

    // A well-formed command (with its argument where it takes one), a mouse report,
    // or a stray byte. Returns the number of beats sent.
    task automatic random_sequence(input logic kind, output int beats);
        logic [7:0] c;
        logic [7:0] arg;
        logic       takes_arg;
        int         r;
        r     = $urandom_range(0, 99);
        beats = 1;
        if (r < 25) begin
            send_beat(report_item(random_move(), random_move(), 3'($urandom())));
        end else if (r < 82) begin
            c = pick_command(kind);
            send_host(c);
            takes_arg = (c == CMD_RATE) ||
                        (kind == KIND_KEYBOARD && (c == CMD_LEDS || c == CMD_SCANSET)) ||
                        (kind == KIND_MOUSE && (c == CMD_SCALING || c == CMD_RES));
            if (takes_arg) begin
                if ($urandom_range(0, 9) == 0) begin
                    // report slipped in while the argument is still open
                    send_beat(report_item(random_move(), random_move(), 3'($urandom())));
                    beats++;
                end
                if (c == CMD_SCANSET && $urandom_range(0, 1))
                    arg = 8'h00;
                else if ($urandom_range(0, 5) == 0)
                    arg = pick_command(1'($urandom()));
                else
                    arg = 8'($urandom());
                send_host(arg);
                beats++;
            end
        end else begin
            // noise: any byte, including commands of the other kind
            send_host(8'($urandom()));
        end
    endtask

    initial begin
        int sent;
        int beats;
        int phase_goal;
        logic kind;
        model = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, keyboard first: echo, ID, LED argument that looks like a command
        set_device_kind(KIND_KEYBOARD);
        send_host(CMD_ECHO);
        send_host(CMD_GET_ID);
        send_host(CMD_LEDS);
        send_host(CMD_RESET);
        // scancode set query answers with set 2
        send_host(CMD_SCANSET);
        send_host(8'h00);
        // report while an argument is open, at the field extremes
        send_host(CMD_SCANSET);
        send_beat(report_item(16'sh8000, 16'sh7FFF, 3'd7));
        send_host(8'h02);
        send_host(CMD_RATE);
        send_host(8'h00);
        send_host(CMD_DEFAULTS);
        send_host(CMD_RESEND);
        send_host(CMD_RESET);
        send_host(CMD_SCALING);            // mouse-only command on a keyboard
        send_beat(report_item(16'sd255, -16'sd256, 3'd1));
        send_beat(report_item(16'sd256, -16'sd255, 3'd2));
        send_beat(report_item(16'sd0, 16'sd0, 3'd4));
        // kind switched while the scancode argument is pending
        send_host(CMD_SCANSET);
        set_device_kind(KIND_MOUSE);
        send_host(8'h00);
        send_host(CMD_SCALING);
        send_host(8'h01);
        send_host(CMD_RES);
        send_host(8'h03);
        send_host(CMD_GET_ID);
        send_host(CMD_LEDS);               // keyboard-only command on a mouse

        // Random part in phases, the kind flipping between them
        sent = 0;
        kind = KIND_MOUSE;
        while (sent < RANDOM_ITEMS) begin
            kind = ~kind;
            set_device_kind(kind);
            phase_goal = sent + $urandom_range(30, 80);
            while (sent < phase_goal && sent < RANDOM_ITEMS) begin
                random_sequence(kind, beats);
                sent += beats;
            end
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (model.outstanding() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.errors == 0 && model.outstanding() == 0)
            $display("ps2_device_command_responder test passed");
        else
            $display("ps2_device_command_responder test failed");
        $finish;
    end
endmodule
